// File: rtl/vbpd_pkg.sv
`default_nettype none

package vbpd_pkg;

  localparam int unsigned AddrW  = 13;
  localparam int unsigned PixW   = 4;
  localparam int unsigned NumPix = 8;

  localparam logic [AddrW-1:0] PaletteEndReset = 13'd8000;

  localparam logic [3:0] ModeCol40    = 4'd0;
  localparam logic [3:0] ModeBitmap4  = 4'd1;
  localparam logic [3:0] ModePage1    = 4'd2;
  localparam logic [3:0] ModePage2    = 4'd3;
  localparam logic [3:0] ModeStack2   = 4'd4;
  localparam logic [3:0] ModeCol80    = 4'd5;
  localparam logic [3:0] ModeStack4   = 4'd6;
  localparam logic [3:0] ModeBitmap4b = 4'd7;
  localparam logic [3:0] ModeBitmap16 = 4'd8;
  localparam logic [3:0] ModePalette  = 4'd9;

  localparam logic [7:0] PalKeyMask  = 8'h78;
  localparam logic [7:0] PalKeyMatch = 8'h30;
  localparam logic [3:0] PalColA     = 4'd7;
  localparam logic [3:0] PalColB     = 4'd8;

  typedef struct packed {
    logic [3:0]       command;
    logic [AddrW-1:0] byte_address;
    logic [7:0]       shape_byte;
    logic [7:0]       colour_byte;
  } item_t;

  typedef struct packed {
    logic [PixW-1:0] pixel0;
    logic [PixW-1:0] pixel1;
    logic [PixW-1:0] pixel2;
    logic [PixW-1:0] pixel3;
    logic [PixW-1:0] pixel4;
    logic [PixW-1:0] pixel5;
    logic [PixW-1:0] pixel6;
    logic [PixW-1:0] pixel7;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/vbpd_decode.sv
`default_nettype none

module vbpd_decode (
  input  vbpd_pkg::item_t                 item_i,
  input  logic [vbpd_pkg::AddrW-1:0]      palette_end_i,
  output vbpd_pkg::result_t               result_o
);

  logic [7:0] shp;
  logic [7:0] clr;
  logic [3:0] fg;
  logic [3:0] bg;
  logic [3:0] pal_a;
  logic [3:0] pal_b;
  logic       in_palette;
  logic [3:0] pix [vbpd_pkg::NumPix];

  assign shp        = item_i.shape_byte;
  assign clr        = item_i.colour_byte;
  assign fg         = {~clr[6], clr[5:3]};
  assign bg         = {~clr[7], clr[2:0]};
  assign in_palette = item_i.byte_address < palette_end_i;

  always_comb begin
    if ((clr & vbpd_pkg::PalKeyMask) == vbpd_pkg::PalKeyMatch) begin
      pal_a = vbpd_pkg::PalColA;
      pal_b = vbpd_pkg::PalColB;
    end else begin
      pal_a = vbpd_pkg::PalColB;
      pal_b = vbpd_pkg::PalColA;
    end
  end

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      case (item_i.command)
        vbpd_pkg::ModeBitmap4: begin
          pix[i] = {2'b00, shp[7-i], clr[7-i]};
        end
        vbpd_pkg::ModePage1: begin
          pix[i] = {3'b000, shp[7-i]};
        end
        vbpd_pkg::ModePage2: begin
          pix[i] = {2'b00, clr[7-i], 1'b0};
        end
        vbpd_pkg::ModeStack2: begin
          if (shp[7-i]) begin
            pix[i] = 4'd1;
          end else begin
            pix[i] = clr[7-i] ? 4'd2 : 4'd0;
          end
        end
        vbpd_pkg::ModeCol80: begin
          if (i < 4) begin
            pix[i] = {3'b000, shp[6-2*(i%4)]};
          end else begin
            pix[i] = {3'b000, clr[6-2*(i%4)]};
          end
        end
        vbpd_pkg::ModeStack4: begin
          if (shp[7-i/2]) begin
            pix[i] = 4'd1;
          end else if (shp[3-i/2]) begin
            pix[i] = 4'd2;
          end else if (clr[7-i/2]) begin
            pix[i] = 4'd3;
          end else if (clr[3-i/2]) begin
            pix[i] = 4'd4;
          end else begin
            pix[i] = 4'd0;
          end
        end
        vbpd_pkg::ModeBitmap4b: begin
          if (i < 4) begin
            pix[i] = {2'b00, shp[7-2*(i%4)], shp[6-2*(i%4)]};
          end else begin
            pix[i] = {2'b00, clr[7-2*(i%4)], clr[6-2*(i%4)]};
          end
        end
        vbpd_pkg::ModeBitmap16: begin
          case (i / 2)
            0:       pix[i] = shp[7:4];
            1:       pix[i] = shp[3:0];
            2:       pix[i] = clr[7:4];
            default: pix[i] = clr[3:0];
          endcase
        end
        vbpd_pkg::ModePalette: begin
          if (in_palette) begin
            pix[i] = shp[7-i] ? pal_a : pal_b;
          end else begin
            pix[i] = shp[7-i] ? fg : bg;
          end
        end
        default: begin
          pix[i] = shp[7-i] ? fg : bg;
        end
      endcase
    end
  end

  assign result_o.pixel0 = pix[0];
  assign result_o.pixel1 = pix[1];
  assign result_o.pixel2 = pix[2];
  assign result_o.pixel3 = pix[3];
  assign result_o.pixel4 = pix[4];
  assign result_o.pixel5 = pix[5];
  assign result_o.pixel6 = pix[6];
  assign result_o.pixel7 = pix[7];

endmodule

`default_nettype wire

// File: rtl/video_byte_pair_pixel_decoder.sv
// channel   | handshake                   | payload
// ----------+-----------------------------+-------------------------------
// item in   | start_i, busy_o             | item_i (command, address, bytes)
// result    | done_o (one-cycle strobe)   | result_o (pixel0..pixel7)
// config    | cfg_valid_i, cfg_ready_o    | cfg_data_i (palette area end)
//
// one item per cycle; the result strobes once the item has passed the input
// register, then decode into the result register
// busy_o and cfg_ready_o stay low and high; nothing stalls
// reset clears the stage valids and sets the palette area end to 8000
`default_nettype none

module video_byte_pair_pixel_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  vbpd_pkg::item_t               item_i,
  output logic                          done_o,
  output vbpd_pkg::result_t             result_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [vbpd_pkg::AddrW-1:0]    cfg_data_i
);

  logic                       in_valid_q;
  vbpd_pkg::item_t            in_item_q;
  logic [vbpd_pkg::AddrW-1:0] pal_end_q;
  logic                       done_q;
  vbpd_pkg::result_t          result_d;
  vbpd_pkg::result_t          result_q;

  assign busy_o      = 1'b0;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
      done_q     <= 1'b0;
      pal_end_q  <= vbpd_pkg::PaletteEndReset;
    end else begin
      in_valid_q <= start_i && !busy_o;
      done_q     <= in_valid_q;
      if (cfg_valid_i && cfg_ready_o) begin
        pal_end_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_o) begin
      in_item_q <= item_i;
    end
    if (in_valid_q) begin
      result_q <= result_d;
    end
  end

  vbpd_decode u_decode (
    .item_i        (in_item_q),
    .palette_end_i (pal_end_q),
    .result_o      (result_d)
  );

  assign done_o   = done_q;
  assign result_o = result_q;

  a_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> in_valid_q)
    else $error("accepted item not registered");

  a_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q |=> done_o)
    else $error("registered item gave no result");

  a_nodone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |=> !done_o)
    else $error("result without item");

  a_page1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && in_item_q.command == vbpd_pkg::ModePage1
    |=> result_o.pixel0[3:1] == 3'b000 && result_o.pixel7[3:1] == 3'b000)
    else $error("page1 pixel out of range");

endmodule

`default_nettype wire
